FILE: src/blk2s_pkg.sv
// shared types, constants and tables of the blake2s engine
package blk2s_pkg;

    localparam int BLOCK_BYTES  = 64;
    localparam int DIGEST_BYTES = 32;
    localparam int KEY_BYTES    = 32;
    localparam int ROUNDS       = 10;
    localparam int STEPS        = ROUNDS * 4;
    localparam int STEP_W       = $clog2(STEPS);

    localparam logic [31:0] PARAM_BASE = 32'h0101_0000;

    localparam logic [31:0] IV [0:7] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [3:0] SIGMA [0:ROUNDS-1][0:15] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
    };

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last_word;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_bytes;
        logic        last_result;
    } out_item_t;

    typedef struct packed {
        logic [5:0]   digest_length;
        logic [5:0]   key_length;
        logic [255:0] key;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_LOAD,
        OP_PUT,
        OP_CSTART,
        OP_FSTART,
        OP_ROUND,
        OP_CFIN,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [3:0] rnd;
        logic       diag;
        logic       phase;
        logic [2:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic fill_full;
        logic cnt_zero;
        logic last_item;
        logic emit_last;
    } dp_stat_t;

    typedef enum logic [2:0] {
        REG_DIGEST_LEN = 3'd0,
        REG_KEY_LEN    = 3'd1,
        REG_KEY_0      = 3'd2,
        REG_KEY_1      = 3'd3,
        REG_KEY_2      = 3'd4,
        REG_KEY_3      = 3'd5
    } reg_idx_t;

    function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] k);
        logic [3:0] s;
        s = '0;
        if (r < 4'(ROUNDS))
        begin
            s = SIGMA[r][k];
        end
        return s;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

FILE: src/blk2s_dp.sv
// blake2s datapath: block buffer, chain value, working vector and half-g mixing lanes
module blk2s_dp
    import blk2s_pkg::*;
(
    input  logic      clk,
    input  dp_cmd_t   cmd,
    input  cfg_t      cfg,
    input  in_item_t  in_data,
    output dp_stat_t  stat,
    output out_item_t out_data
);

    logic [31:0] chain_reg [0:7];
    logic [31:0] buf_reg   [0:15];
    logic [31:0] v_reg     [0:15];
    logic [31:0] v_next    [0:15];
    logic [63:0] total_reg;
    logic [6:0]  fill_reg;
    logic [31:0] word_reg;
    logic [2:0]  cnt_reg;
    logic        last_reg;
    out_item_t   out_reg;

    logic [5:0]  dl;
    logic [5:0]  kl;
    logic [31:0] key_blk [0:15];
    logic [63:0] t_new;
    logic [5:0]  pos;
    logic [5:0]  rem;
    logic [2:0]  nb;
    logic [3:0]  idx_up;
    logic [31:0] emit_word;

    always_comb
    begin
        if (cfg.digest_length == 6'd0)
            dl = 6'd1;
        else if (cfg.digest_length > 6'(DIGEST_BYTES))
            dl = 6'(DIGEST_BYTES);
        else
            dl = cfg.digest_length;
        kl = (cfg.key_length > 6'(KEY_BYTES)) ? 6'(KEY_BYTES) : cfg.key_length;
    end

    // key bytes beyond the key length read as zero
    always_comb
    begin
        for (int w = 0; w < 16; w++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                if ((4 * w + b) < KEY_BYTES && 6'(4 * w + b) < kl)
                    key_blk[w][8*b +: 8] = cfg.key[8*((4*w+b) % KEY_BYTES) +: 8];
                else
                    key_blk[w][8*b +: 8] = 8'h00;
            end
        end
    end

    assign t_new = total_reg + ((cmd.op == OP_FSTART) ? {57'd0, fill_reg}
                                                      : 64'(BLOCK_BYTES));
    assign pos   = fill_reg[5:0];

    // four half-g lanes, column or diagonal
    always_comb
    begin
        logic [3:0]  ia, ib, ic, id;
        logic [1:0]  jj;
        logic [31:0] a, b, c, d, x;
        for (int i = 0; i < 16; i++)
        begin
            v_next[i] = v_reg[i];
        end
        for (int j = 0; j < 4; j++)
        begin
            jj = 2'(j);
            ia = {2'b00, jj};
            ib = {2'b01, cmd.diag ? 2'(jj + 2'd1) : jj};
            ic = {2'b10, cmd.diag ? 2'(jj + 2'd2) : jj};
            id = {2'b11, cmd.diag ? 2'(jj + 2'd3) : jj};
            x  = buf_reg[sigma(cmd.rnd, {cmd.diag, jj, cmd.phase})];
            a  = v_reg[ia] + v_reg[ib] + x;
            if (!cmd.phase)
            begin
                d = rotr(v_reg[id] ^ a, 16);
                c = v_reg[ic] + d;
                b = rotr(v_reg[ib] ^ c, 12);
            end
            else
            begin
                d = rotr(v_reg[id] ^ a, 8);
                c = v_reg[ic] + d;
                b = rotr(v_reg[ib] ^ c, 7);
            end
            v_next[ia] = a;
            v_next[ib] = b;
            v_next[ic] = c;
            v_next[id] = d;
        end
    end

    // digest word selection and truncation
    always_comb
    begin
        rem = dl - {1'b0, cmd.idx, 2'b00};
        nb  = (rem > 6'd4) ? 3'd4 : rem[2:0];
        idx_up = {1'b0, cmd.idx} + 4'd1;
        case (nb)
            3'd1:    emit_word = chain_reg[cmd.idx] & 32'h0000_00FF;
            3'd2:    emit_word = chain_reg[cmd.idx] & 32'h0000_FFFF;
            3'd3:    emit_word = chain_reg[cmd.idx] & 32'h00FF_FFFF;
            default: emit_word = chain_reg[cmd.idx];
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_INIT:
            begin
                chain_reg[0] <= IV[0] ^ PARAM_BASE ^ {18'd0, kl, 8'd0} ^ {26'd0, dl};
                for (int i = 1; i < 8; i++)
                begin
                    chain_reg[i] <= IV[i];
                end
                for (int i = 0; i < 16; i++)
                begin
                    buf_reg[i] <= key_blk[i];
                end
                total_reg <= '0;
                fill_reg  <= (kl != 6'd0) ? 7'(BLOCK_BYTES) : 7'd0;
            end
            OP_LOAD:
            begin
                word_reg <= in_data.data_word;
                cnt_reg  <= (in_data.byte_count > 3'd4) ? 3'd4 : in_data.byte_count;
                last_reg <= in_data.last_word;
            end
            OP_PUT:
            begin
                buf_reg[pos[5:2]] <= buf_reg[pos[5:2]]
                                     | ({24'd0, word_reg[7:0]} << {pos[1:0], 3'b000});
                fill_reg <= {1'b0, pos} + 7'd1;
                word_reg <= word_reg >> 8;
                cnt_reg  <= cnt_reg - 3'd1;
            end
            OP_CSTART, OP_FSTART:
            begin
                total_reg <= t_new;
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i]     <= chain_reg[i];
                    v_reg[8 + i] <= IV[i];
                end
                v_reg[12] <= IV[4] ^ t_new[31:0];
                v_reg[13] <= IV[5] ^ t_new[63:32];
                if (cmd.op == OP_FSTART)
                    v_reg[14] <= ~IV[6];
            end
            OP_ROUND:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    v_reg[i] <= v_next[i];
                end
            end
            OP_CFIN:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= chain_reg[i] ^ v_reg[i] ^ v_reg[8 + i];
                end
                for (int i = 0; i < 16; i++)
                begin
                    buf_reg[i] <= '0;
                end
                fill_reg <= '0;
            end
            OP_EMIT:
            begin
                out_reg.digest_word <= emit_word;
                out_reg.word_bytes  <= nb;
                out_reg.last_result <= (dl <= {idx_up, 2'b00});
            end
            default:
            begin
            end
        endcase
    end

    assign stat.fill_full = fill_reg[6];
    assign stat.cnt_zero  = (cnt_reg == 3'd0);
    assign stat.last_item = last_reg;
    assign stat.emit_last = (dl <= {idx_up, 2'b00});
    assign out_data       = out_reg;

endmodule

FILE: src/blk2s_ctrl.sv
// blake2s controller: item intake, byte loading, round sequencing and digest output
module blk2s_ctrl
    import blk2s_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_INIT  = 6'b000010,
        S_BYTE  = 6'b000100,
        S_ROUND = 6'b001000,
        S_FEED  = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [2:0]        idx_reg, idx_next;
    logic              final_reg, final_next;
    logic              in_msg_reg, in_msg_next;
    logic              ovalid_reg, ovalid_next;
    logic              slot_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ovalid_reg;
    assign slot_free = !ovalid_reg || !out_stall;

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        idx_next    = idx_reg;
        final_next  = final_reg;
        in_msg_next = in_msg_reg;
        ovalid_next = ovalid_reg && out_stall;
        cmd.op      = OP_NONE;
        cmd.rnd     = 4'(step_reg >> 2);
        cmd.diag    = step_reg[1];
        cmd.phase   = step_reg[0];
        cmd.idx     = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op      = OP_LOAD;
                    in_msg_next = 1'b1;
                    state_next  = in_msg_reg ? S_BYTE : S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.op     = OP_INIT;
                state_next = S_BYTE;
            end
            S_BYTE:
            begin
                step_next = '0;
                if (stat.cnt_zero)
                begin
                    if (stat.last_item)
                    begin
                        cmd.op     = OP_FSTART;
                        final_next = 1'b1;
                        state_next = S_ROUND;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (stat.fill_full)
                begin
                    // more bytes follow a full block: compress it first
                    cmd.op     = OP_CSTART;
                    final_next = 1'b0;
                    state_next = S_ROUND;
                end
                else
                begin
                    cmd.op = OP_PUT;
                end
            end
            S_ROUND:
            begin
                cmd.op    = OP_ROUND;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(STEPS - 1))
                    state_next = S_FEED;
            end
            S_FEED:
            begin
                cmd.op   = OP_CFIN;
                idx_next = '0;
                state_next = final_reg ? S_EMIT : S_BYTE;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.op      = OP_EMIT;
                    ovalid_next = 1'b1;
                    idx_next    = idx_reg + 3'd1;
                    if (stat.emit_last)
                    begin
                        in_msg_next = 1'b0;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            step_reg   <= '0;
            idx_reg    <= '0;
            final_reg  <= 1'b0;
            in_msg_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            idx_reg    <= idx_next;
            final_reg  <= final_next;
            in_msg_reg <= in_msg_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

FILE: src/blake2s_keyed_hash.sv
// top level of the blake2s keyed hash engine with its register port
// BLAKE2s hash engine (RFC 7693) with optional key. Each input beat carries up to four
// message bytes, little-endian, plus a last mark; bytes are loaded into the block buffer one
// per cycle while no block is being compressed. A block is compressed only once a byte beyond
// it arrives, in ten rounds on four half-g lanes that mix a column or diagonal per pass, plus
// setup and feed-forward. The first beat of a message passes an init state that loads the
// chain value and key block from the registers, so key and key length writes take effect at
// the next message, while the digest length is read again on output. After the last beat the
// final block is compressed and the digest leaves as one to eight output beats, one per cycle
// when the output is not stalled. No input is taken while a beat is in work.
module blake2s_keyed_hash
    import blk2s_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [5:0]  dlen_reg;
    logic [5:0]  klen_reg;
    logic [63:0] key_reg [0:3];
    logic        wr_en;
    logic [2:0]  reg_sel;
    cfg_t        cfg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dlen_reg <= 6'(DIGEST_BYTES);
            klen_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_DIGEST_LEN: dlen_reg   <= pwdata[5:0];
                REG_KEY_LEN:    klen_reg   <= pwdata[5:0];
                REG_KEY_0:      key_reg[0] <= pwdata;
                REG_KEY_1:      key_reg[1] <= pwdata;
                REG_KEY_2:      key_reg[2] <= pwdata;
                REG_KEY_3:      key_reg[3] <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_DIGEST_LEN: prdata = {58'd0, dlen_reg};
            REG_KEY_LEN:    prdata = {58'd0, klen_reg};
            REG_KEY_0:      prdata = key_reg[0];
            REG_KEY_1:      prdata = key_reg[1];
            REG_KEY_2:      prdata = key_reg[2];
            REG_KEY_3:      prdata = key_reg[3];
            default:        prdata = '0;
        endcase
    end

    assign cfg.digest_length = dlen_reg;
    assign cfg.key_length    = klen_reg;
    assign cfg.key           = {key_reg[3], key_reg[2], key_reg[1], key_reg[0]};

    blk2s_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    blk2s_dp u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .cfg      (cfg),
        .in_data  (in_data),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule
